FILE: hdl/fbnhs_pkg.sv
// shared types, constants and helper functions of the next hop selector
package fbnhs_pkg;

  localparam int FLOW_ENTRIES_DEF = 64;
  localparam int PORT_CNT_DEF     = 64;

  localparam int PORT_W  = 6;
  localparam int KEY_W   = 16;
  localparam int STAMP_W = 32;
  localparam int LOAD_W  = 7;
  localparam int CAND_W  = 64;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [LOAD_W-1:0]  LOAD_MAX    = 7'd127;
  localparam logic [WORD_W-1:0]  LFSR_TAPS   = 32'h8020_0003;
  localparam logic [WORD_W-1:0]  TIMEOUT_RST = 32'd60000;
  localparam logic [WORD_W-1:0]  SEED_RST    = 32'd1;
  localparam logic [KEY_W-1:0]   CRC_POLY    = 16'hA001;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd2;

  localparam logic MODE_LEAST  = 1'b0;
  localparam logic MODE_RANDOM = 1'b1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [1:0] STATUS_EXIST = 2'd0;
  localparam logic [1:0] STATUS_NEW   = 2'd1;
  localparam logic [1:0] STATUS_NONE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_WALK,
    CMD_PACK,
    CMD_PUSH
  } flow_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC,
    ST_WALK,
    ST_PACK,
    ST_DECIDE,
    ST_LEAST,
    ST_COUNT,
    ST_DIV,
    ST_PICK,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
  } flow_ent_t;

  typedef struct packed {
    logic              hit;
    logic              drop;
    logic              stop;
    logic [PORT_W-1:0] port;
  } flow_rpt_t;

  typedef struct packed {
    logic              rot;
    logic              inc;
    logic              dec;
    logic [PORT_W-1:0] inc_port;
    logic [PORT_W-1:0] dec_port;
  } port_ctl_t;

  function automatic logic [KEY_W-1:0] crc_byte(input logic [KEY_W-1:0] crc,
                                                input logic [7:0] b);
    logic [KEY_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] lfsr_next(input logic [WORD_W-1:0] v);
    return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
  endfunction

endpackage

FILE: hdl/fbnhs_flow_cell.sv
// one flow table cell: holds one entry, ages it, compares its key, shifts along the chain
module fbnhs_flow_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbnhs_pkg::flow_cmd_e          cmd_i,
  input  fbnhs_pkg::flow_ent_t          prev_i,
  input  fbnhs_pkg::flow_ent_t          next_i,
  input  logic                          shift_i,
  output logic                          shift_o,
  input  logic                          tok_i,
  output logic                          tok_o,
  input  logic [fbnhs_pkg::KEY_W-1:0]   key_i,
  input  logic [fbnhs_pkg::STAMP_W-1:0] now_i,
  input  logic [fbnhs_pkg::STAMP_W-1:0] timeout_i,
  output fbnhs_pkg::flow_ent_t          ent_o,
  output fbnhs_pkg::flow_rpt_t          rpt_o
);

  logic                          valid_q, valid_d;
  logic [fbnhs_pkg::KEY_W-1:0]   key_q, key_d;
  logic [fbnhs_pkg::PORT_W-1:0]  port_q, port_d;
  logic [fbnhs_pkg::STAMP_W-1:0] stamp_q, stamp_d;
  logic                          tok_q;
  logic [fbnhs_pkg::STAMP_W-1:0] idle;
  logic                          expired, hit_live, examining, take_next;

  assign idle      = now_i - stamp_q;
  assign expired   = idle > timeout_i;
  assign hit_live  = valid_q && !expired && (key_q == key_i);
  assign examining = tok_q && (cmd_i == fbnhs_pkg::CMD_WALK);
  // first hole at or before this cell pulls everything behind it one step forward
  assign take_next = shift_i || !valid_q;
  assign shift_o   = take_next;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    port_d  = port_q;
    stamp_d = stamp_q;
    unique case (cmd_i)
      fbnhs_pkg::CMD_HOLD: begin
      end
      fbnhs_pkg::CMD_WALK: begin
        if (examining && valid_q && expired) begin
          valid_d = 1'b0;
        end else if (examining && hit_live) begin
          stamp_d = now_i;
        end
      end
      fbnhs_pkg::CMD_PACK: begin
        if (take_next) begin
          valid_d = next_i.valid;
          key_d   = next_i.key;
          port_d  = next_i.port;
          stamp_d = next_i.stamp;
        end
      end
      fbnhs_pkg::CMD_PUSH: begin
        valid_d = prev_i.valid;
        key_d   = prev_i.key;
        port_d  = prev_i.port;
        stamp_d = prev_i.stamp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    port_q  <= port_d;
    stamp_q <= stamp_d;
  end

  assign tok_o = examining && valid_q && !hit_live;

  assign ent_o.valid = valid_q;
  assign ent_o.key   = key_q;
  assign ent_o.port  = port_q;
  assign ent_o.stamp = stamp_q;

  assign rpt_o.hit  = examining && hit_live;
  assign rpt_o.drop = examining && valid_q && expired;
  assign rpt_o.stop = examining && (!valid_q || hit_live);
  assign rpt_o.port = examining ? port_q : '0;

endmodule

FILE: hdl/fbnhs_port_cell.sv
// one port load cell: flow count of one port, rotates along the ring during a scan
module fbnhs_port_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fbnhs_pkg::PORT_W-1:0] idx_i,
  input  fbnhs_pkg::port_ctl_t         ctl_i,
  input  logic [fbnhs_pkg::LOAD_W-1:0] next_load_i,
  output logic [fbnhs_pkg::LOAD_W-1:0] load_o
);

  logic [fbnhs_pkg::LOAD_W-1:0] load_q, load_d;

  always_comb begin
    load_d = load_q;
    priority if (ctl_i.rot) begin
      load_d = next_load_i;
    end else if (ctl_i.inc && ctl_i.inc_port == idx_i && load_q != fbnhs_pkg::LOAD_MAX) begin
      load_d = load_q + 1'b1;
    end else if (ctl_i.dec && ctl_i.dec_port == idx_i && load_q != '0) begin
      load_d = load_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else begin
      load_q <= load_d;
    end
  end

  assign load_o = load_q;

endmodule

FILE: hdl/flow_balancing_next_hop_select_unit.sv
// top level: flow hash, flow table cell chain, port load ring and control sequencer
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------------
//  item in  | start_i / busy_o    | kind_i, src/dst addr, qos, endpoints, candidates
//  result   | valid_o (one cycle) | port_o, status_o, flow_hash_o
//  config   | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// a tick beat gives no result; busy_o stays low
// a packet beat: crc over 20 bytes (one byte a cycle), a walk of one flow cell a
// cycle up to FLOW_ENTRIES cells, a repack until no hole is left, a decide step,
// then a scan of the PORT_CNT ports (least flows) or a count, divide and pick
// (random), and a store of the new entry; valid_o is high in the cycle after the
// last busy cycle
// reset clears the table valid bits, the port loads and the clock at once
// results cannot be held off by the receiver
module flow_balancing_next_hop_select_unit #(
  parameter int FLOW_ENTRIES = fbnhs_pkg::FLOW_ENTRIES_DEF,
  parameter int PORT_CNT     = fbnhs_pkg::PORT_CNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            kind_i,
  input  logic [fbnhs_pkg::WORD_W-1:0]    src_addr_i,
  input  logic [fbnhs_pkg::WORD_W-1:0]    dst_addr_i,
  input  logic [fbnhs_pkg::WORD_W-1:0]    qos_class_i,
  input  logic [fbnhs_pkg::WORD_W-1:0]    src_endpoint_i,
  input  logic [fbnhs_pkg::WORD_W-1:0]    dst_endpoint_i,
  input  logic [fbnhs_pkg::CAND_W-1:0]    candidate_ports_i,
  output logic                            valid_o,
  output logic [fbnhs_pkg::PORT_W-1:0]    port_o,
  output logic [1:0]                      status_o,
  output logic [fbnhs_pkg::KEY_W-1:0]     flow_hash_o,
  input  logic                            cfg_we_i,
  input  logic [fbnhs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbnhs_pkg::WORD_W-1:0]    cfg_data_i
);

  localparam int BYTES = 20;
  localparam int BYTE_CNT_W = $clog2(BYTES);
  localparam int DIV_CNT_W = $clog2(fbnhs_pkg::WORD_W);
  localparam int CNT_W = fbnhs_pkg::PORT_W + 1;

  fbnhs_pkg::state_e state_q, state_d;

  logic                         mode_q;
  logic [fbnhs_pkg::WORD_W-1:0] timeout_q, lfsr_q, now_q;
  logic                         out_valid_q;
  logic [fbnhs_pkg::PORT_W-1:0] out_port_q;
  logic [1:0]                   out_status_q;
  logic [fbnhs_pkg::KEY_W-1:0]  out_hash_q;

  logic [BYTES*8-1:0]           data_q;
  logic [BYTE_CNT_W-1:0]        byte_q;
  logic [fbnhs_pkg::KEY_W-1:0]  crc_q;
  logic [PORT_CNT-1:0]          mask_q;
  logic                         found_q, ok_q;
  logic [fbnhs_pkg::PORT_W-1:0] fport_q, p_q, pick_q;
  logic [fbnhs_pkg::LOAD_W-1:0] best_q;
  logic [CNT_W-1:0]             cnt_q, k_q;
  logic [fbnhs_pkg::PORT_W-1:0] rem_q;
  logic [fbnhs_pkg::WORD_W-1:0] div_q;
  logic [DIV_CNT_W-1:0]         dcnt_q;

  fbnhs_pkg::flow_cmd_e fcmd;
  logic                 seed;
  fbnhs_pkg::port_ctl_t pctl;
  logic                 emit, lfsr_step;
  logic [1:0]           emit_status;
  logic [fbnhs_pkg::PORT_W-1:0] emit_port;

  fbnhs_pkg::flow_ent_t ent [FLOW_ENTRIES];
  fbnhs_pkg::flow_rpt_t rpt [FLOW_ENTRIES];
  logic [FLOW_ENTRIES-1:0] shift, tok;
  fbnhs_pkg::flow_ent_t new_ent, end_ent;
  fbnhs_pkg::flow_rpt_t rpt_all;
  logic hole, full, walk_stop;

  logic [fbnhs_pkg::LOAD_W-1:0] load [PORT_CNT];

  logic accept, pkt_accept, tick_accept;
  logic last_byte, last_p, hit_ok, no_mask, better, ok_nxt;
  logic [fbnhs_pkg::CAND_W-1:0] mask_wide;
  logic [CNT_W-1:0] rem_t;

  assign busy_o      = (state_q != fbnhs_pkg::ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign pkt_accept  = accept && (kind_i == fbnhs_pkg::KIND_PACKET);
  assign tick_accept = accept && (kind_i == fbnhs_pkg::KIND_TICK);

  assign last_byte = (byte_q == BYTE_CNT_W'(BYTES - 1));
  assign last_p    = (p_q == fbnhs_pkg::PORT_W'(PORT_CNT - 1));
  assign mask_wide = fbnhs_pkg::CAND_W'(mask_q);
  assign hit_ok    = found_q && mask_wide[fport_q];
  assign no_mask   = (mask_q == '0);
  // head of the rotating ring is port p_q
  assign better    = mask_q[0] && (p_q != '0) && (!ok_q || load[0] < best_q);
  assign ok_nxt    = ok_q || better;
  assign rem_t     = {rem_q, div_q[fbnhs_pkg::WORD_W-1]};

  // flow table chain
  assign new_ent.valid = 1'b1;
  assign new_ent.key   = crc_q;
  assign new_ent.port  = pick_q;
  assign new_ent.stamp = now_q;
  assign end_ent       = '0;

  for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_flow
    fbnhs_flow_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (fcmd),
      .prev_i    ((i == 0) ? new_ent : ent[(i + FLOW_ENTRIES - 1) % FLOW_ENTRIES]),
      .next_i    ((i == FLOW_ENTRIES - 1) ? end_ent : ent[(i + 1) % FLOW_ENTRIES]),
      .shift_i   ((i == 0) ? 1'b0 : shift[(i + FLOW_ENTRIES - 1) % FLOW_ENTRIES]),
      .shift_o   (shift[i]),
      .tok_i     ((i == 0) ? seed : tok[(i + FLOW_ENTRIES - 1) % FLOW_ENTRIES]),
      .tok_o     (tok[i]),
      .key_i     (crc_q),
      .now_i     (now_q),
      .timeout_i (timeout_q),
      .ent_o     (ent[i]),
      .rpt_o     (rpt[i])
    );
  end

  // only the cell holding the walk token reports, so the reports merge by or
  always_comb begin
    rpt_all = '0;
    hole    = 1'b0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      rpt_all = rpt_all | rpt[i];
    end
    for (int i = 0; i < FLOW_ENTRIES - 1; i++) begin
      hole = hole | (!ent[i].valid && ent[i+1].valid);
    end
  end

  assign full      = ent[FLOW_ENTRIES-1].valid;
  assign walk_stop = rpt_all.stop || tok[FLOW_ENTRIES-1];

  // port load ring
  for (genvar i = 0; i < PORT_CNT; i++) begin : g_port
    fbnhs_port_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (fbnhs_pkg::PORT_W'(i)),
      .ctl_i       (pctl),
      .next_load_i (load[(i + 1) % PORT_CNT]),
      .load_o      (load[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbnhs_pkg::ST_IDLE:   if (pkt_accept) state_d = fbnhs_pkg::ST_CRC;
      fbnhs_pkg::ST_CRC:    if (last_byte) state_d = fbnhs_pkg::ST_WALK;
      fbnhs_pkg::ST_WALK:   if (walk_stop) state_d = fbnhs_pkg::ST_PACK;
      fbnhs_pkg::ST_PACK:   if (!hole) state_d = fbnhs_pkg::ST_DECIDE;
      fbnhs_pkg::ST_DECIDE: begin
        priority if (hit_ok || full || no_mask) begin
          state_d = fbnhs_pkg::ST_IDLE;
        end else if (mode_q == fbnhs_pkg::MODE_RANDOM) begin
          state_d = fbnhs_pkg::ST_COUNT;
        end else begin
          state_d = fbnhs_pkg::ST_LEAST;
        end
      end
      fbnhs_pkg::ST_LEAST: begin
        if (last_p) state_d = ok_nxt ? fbnhs_pkg::ST_PUSH : fbnhs_pkg::ST_IDLE;
      end
      fbnhs_pkg::ST_COUNT:  if (last_p) state_d = fbnhs_pkg::ST_DIV;
      fbnhs_pkg::ST_DIV:    if (dcnt_q == '1) state_d = fbnhs_pkg::ST_PICK;
      fbnhs_pkg::ST_PICK:   if (last_p) state_d = fbnhs_pkg::ST_PUSH;
      fbnhs_pkg::ST_PUSH:   state_d = fbnhs_pkg::ST_IDLE;
      default:              state_d = fbnhs_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    fcmd        = fbnhs_pkg::CMD_HOLD;
    seed        = 1'b0;
    pctl        = '0;
    emit        = 1'b0;
    emit_status = fbnhs_pkg::STATUS_NONE;
    emit_port   = '0;
    lfsr_step   = 1'b0;
    unique case (state_q)
      fbnhs_pkg::ST_CRC: seed = last_byte;
      fbnhs_pkg::ST_WALK: begin
        fcmd          = fbnhs_pkg::CMD_WALK;
        pctl.dec      = rpt_all.drop && (mode_q == fbnhs_pkg::MODE_LEAST);
        pctl.dec_port = rpt_all.port;
      end
      fbnhs_pkg::ST_PACK: if (hole) fcmd = fbnhs_pkg::CMD_PACK;
      fbnhs_pkg::ST_DECIDE: begin
        priority if (hit_ok) begin
          emit        = 1'b1;
          emit_status = fbnhs_pkg::STATUS_EXIST;
          emit_port   = fport_q;
        end else if (full || no_mask) begin
          emit = 1'b1;
        end else begin
          lfsr_step = (mode_q == fbnhs_pkg::MODE_RANDOM);
        end
      end
      fbnhs_pkg::ST_LEAST: begin
        pctl.rot = 1'b1;
        emit     = last_p && !ok_nxt;
      end
      fbnhs_pkg::ST_PUSH: begin
        fcmd          = fbnhs_pkg::CMD_PUSH;
        emit          = 1'b1;
        emit_status   = fbnhs_pkg::STATUS_NEW;
        emit_port     = pick_q;
        pctl.inc      = (mode_q == fbnhs_pkg::MODE_LEAST);
        pctl.inc_port = pick_q;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbnhs_pkg::ST_IDLE;
      mode_q      <= fbnhs_pkg::MODE_RANDOM;
      timeout_q   <= fbnhs_pkg::TIMEOUT_RST;
      lfsr_q      <= fbnhs_pkg::SEED_RST;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= emit;
      if (tick_accept) now_q <= now_q + 1'b1;
      if (cfg_we_i && cfg_idx_i == fbnhs_pkg::CFG_MODE) mode_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_idx_i == fbnhs_pkg::CFG_TIMEOUT) timeout_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == fbnhs_pkg::CFG_SEED) begin
        lfsr_q <= (cfg_data_i == '0) ? fbnhs_pkg::SEED_RST : cfg_data_i;
      end else if (lfsr_step) begin
        lfsr_q <= fbnhs_pkg::lfsr_next(lfsr_q);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_port_q   <= emit_port;
      out_status_q <= emit_status;
      out_hash_q   <= crc_q;
    end
    unique case (state_q)
      fbnhs_pkg::ST_IDLE: begin
        if (pkt_accept) begin
          data_q  <= {dst_endpoint_i, src_endpoint_i, qos_class_i, dst_addr_i, src_addr_i};
          byte_q  <= '0;
          crc_q   <= '0;
          mask_q  <= candidate_ports_i[PORT_CNT-1:0];
          found_q <= 1'b0;
        end
      end
      fbnhs_pkg::ST_CRC: begin
        crc_q  <= fbnhs_pkg::crc_byte(crc_q, data_q[7:0]);
        data_q <= data_q >> 8;
        byte_q <= byte_q + 1'b1;
      end
      fbnhs_pkg::ST_WALK: begin
        if (rpt_all.hit) begin
          found_q <= 1'b1;
          fport_q <= rpt_all.port;
        end
      end
      fbnhs_pkg::ST_PACK: begin
      end
      fbnhs_pkg::ST_DECIDE: begin
        p_q    <= '0;
        ok_q   <= 1'b0;
        best_q <= '0;
        pick_q <= '0;
        cnt_q  <= '0;
        k_q    <= '0;
        rem_q  <= '0;
        dcnt_q <= '0;
        div_q  <= fbnhs_pkg::lfsr_next(lfsr_q);
      end
      fbnhs_pkg::ST_LEAST: begin
        mask_q <= {mask_q[0], mask_q[PORT_CNT-1:1]};
        p_q    <= last_p ? '0 : p_q + 1'b1;
        if (better) begin
          ok_q   <= 1'b1;
          best_q <= load[0];
          pick_q <= p_q;
        end
      end
      fbnhs_pkg::ST_COUNT: begin
        mask_q <= {mask_q[0], mask_q[PORT_CNT-1:1]};
        p_q    <= last_p ? '0 : p_q + 1'b1;
        cnt_q  <= cnt_q + CNT_W'(mask_q[0]);
      end
      fbnhs_pkg::ST_DIV: begin
        // restoring remainder, one dividend bit a cycle
        rem_q  <= (rem_t >= cnt_q) ? fbnhs_pkg::PORT_W'(rem_t - cnt_q)
                                   : rem_t[fbnhs_pkg::PORT_W-1:0];
        div_q  <= div_q << 1;
        dcnt_q <= dcnt_q + 1'b1;
      end
      fbnhs_pkg::ST_PICK: begin
        mask_q <= {mask_q[0], mask_q[PORT_CNT-1:1]};
        p_q    <= last_p ? '0 : p_q + 1'b1;
        if (mask_q[0]) begin
          if (k_q == {1'b0, rem_q}) pick_q <= p_q;
          k_q <= k_q + 1'b1;
        end
      end
      fbnhs_pkg::ST_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  assign valid_o     = out_valid_q;
  assign port_o      = out_port_q;
  assign status_o    = out_status_q;
  assign flow_hash_o = out_hash_q;

endmodule

FILE: tb/tb_flow_balancing_next_hop_select_unit.sv
// testbench of the next hop selector: directed table, random phases, flow table predictor
module tb_flow_balancing_next_hop_select_unit;

  localparam int NFLOW      = 64;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic        kind;
    logic [31:0] sa;
    logic [31:0] da;
    logic [31:0] qos;
    logic [31:0] se;
    logic [31:0] de;
    logic [63:0] cand;
  } beat_t;

  typedef struct packed {
    logic [fbnhs_pkg::PORT_W-1:0] port;
    logic [1:0]                   status;
    logic [fbnhs_pkg::KEY_W-1:0]  hash;
  } route_t;

  typedef struct packed {
    beat_t  b;
    logic   fixed;
    route_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic kind_i = 1'b0;
  logic [31:0] src_addr_i = '0, dst_addr_i = '0, qos_class_i = '0;
  logic [31:0] src_endpoint_i = '0, dst_endpoint_i = '0;
  logic [63:0] candidate_ports_i = '0;
  logic valid_o;
  logic [fbnhs_pkg::PORT_W-1:0] port_o;
  logic [1:0] status_o;
  logic [fbnhs_pkg::KEY_W-1:0] flow_hash_o;
  logic cfg_we_i = 1'b0;
  logic [fbnhs_pkg::CFG_IDX_W-1:0] cfg_idx_i = fbnhs_pkg::CFG_MODE;
  logic [31:0] cfg_data_i = '0;

  flow_balancing_next_hop_select_unit dut (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // predictor state
  logic        sel_mode;
  logic [31:0] idle_timeout, seed_reg, lfsr_q, now_q;
  logic        ent_valid[NFLOW];
  logic [15:0] ent_key[NFLOW];
  logic [5:0]  ent_port[NFLOW];
  logic [31:0] ent_stamp[NFLOW];
  int          age_rank[NFLOW];
  int          n_live;
  logic [6:0]  port_load[64];

  route_t routes_q[$];
  int errors = 0;
  int n_pkt = 0, n_tick = 0, n_exist = 0, n_new = 0, n_none = 0;

  function automatic logic [15:0] flow_key_of(beat_t b);
    logic [15:0] c;
    logic [159:0] bytes;
    c = '0;
    bytes = {b.de, b.se, b.qos, b.da, b.sa};
    for (int i = 0; i < 20; i++) begin
      c ^= {8'h00, bytes[8*i +: 8]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_model();
    sel_mode = fbnhs_pkg::MODE_RANDOM;
    idle_timeout = 32'd60000;
    seed_reg = 32'd1;
    lfsr_q = 32'd1;
    now_q = '0;
    n_live = 0;
    for (int i = 0; i < NFLOW; i++) begin
      ent_valid[i] = 1'b0;
      age_rank[i] = 0;
    end
    for (int p = 0; p < 64; p++) port_load[p] = '0;
  endtask

  task automatic drop_at(input int r);
    int s;
    s = age_rank[r];
    if (sel_mode == fbnhs_pkg::MODE_LEAST && port_load[ent_port[s]] > 0) begin
      port_load[ent_port[s]]--;
    end
    ent_valid[s] = 1'b0;
    for (int k = r; k + 1 < n_live; k++) age_rank[k] = age_rank[k + 1];
    n_live--;
  endtask

  task automatic route_packet(input beat_t b, output route_t res);
    logic [15:0] key;
    logic found, ok;
    logic [5:0] fport, port;
    int r, s, cnt, pick, k, best;
    key = flow_key_of(b);
    found = 1'b0;
    ok = 1'b0;
    fport = '0;
    port = '0;
    r = 0;
    res.status = fbnhs_pkg::STATUS_NONE;
    while (r < n_live) begin
      s = age_rank[r];
      if (now_q - ent_stamp[s] > idle_timeout) begin
        drop_at(r);
      end else if (ent_key[s] == key) begin
        ent_stamp[s] = now_q;
        fport = ent_port[s];
        found = 1'b1;
        break;
      end else begin
        r++;
      end
    end
    if (found && b.cand[fport]) begin
      res.status = fbnhs_pkg::STATUS_EXIST;
      port = fport;
    end else if (n_live < NFLOW && b.cand != '0) begin
      if (sel_mode == fbnhs_pkg::MODE_RANDOM) begin
        cnt = $countones(b.cand);
        lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ 32'h8020_0003) : (lfsr_q >> 1);
        pick = int'(lfsr_q % cnt);
        k = 0;
        for (int p = 0; p < 64; p++) begin
          if (b.cand[p]) begin
            if (k == pick && !ok) begin
              port = p[5:0];
              ok = 1'b1;
            end
            k++;
          end
        end
      end else begin
        best = 256;
        for (int p = 1; p < 64; p++) begin
          if (b.cand[p] && port_load[p] < best) begin
            best = port_load[p];
            port = p[5:0];
            ok = 1'b1;
          end
        end
        if (ok && port_load[port] < 7'd127) port_load[port]++;
      end
      if (ok) begin
        s = 0;
        while (ent_valid[s]) s++;
        ent_valid[s] = 1'b1;
        ent_key[s] = key;
        ent_port[s] = port;
        ent_stamp[s] = now_q;
        for (int q = n_live; q > 0; q--) age_rank[q] = age_rank[q - 1];
        age_rank[0] = s;
        n_live++;
        res.status = fbnhs_pkg::STATUS_NEW;
      end else begin
        port = '0;
      end
    end
    res.port = port;
    res.hash = key;
  endtask

  // hold start high until the block takes the beat, then predict it
  task automatic send_beat(input beat_t b, input logic fixed, input route_t want);
    route_t res;
    kind_i <= b.kind;
    src_addr_i <= b.sa;
    dst_addr_i <= b.da;
    qos_class_i <= b.qos;
    src_endpoint_i <= b.se;
    dst_endpoint_i <= b.de;
    candidate_ports_i <= b.cand;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (b.kind == fbnhs_pkg::KIND_TICK) begin
      now_q++;
      n_tick++;
    end else begin
      route_packet(b, res);
      routes_q.push_back(fixed ? want : res);
      n_pkt++;
    end
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (routes_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fbnhs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      fbnhs_pkg::CFG_MODE:    sel_mode = val[0];
      fbnhs_pkg::CFG_TIMEOUT: idle_timeout = val;
      fbnhs_pkg::CFG_SEED: begin
        seed_reg = val;
        lfsr_q = (val == '0) ? 32'd1 : val;
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_mask();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       m = '0;
      1:       m = 64'h1;
      2:       m = 64'h1 << $urandom_range(0, 63);
      3:       m = '1;
      4, 5:    m = m & {$urandom, $urandom} & {$urandom, $urandom};
      6:       m = 64'h8000_0000_0000_0000 | 64'h1;
      default: ;
    endcase
    return m;
  endfunction

  function automatic int rand_gap(input logic busy_run);
    int g;
    g = $urandom_range(0, 19);
    if (busy_run || g < 11) return 0;
    if (g < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // pool of connection tuples so flows come back
  logic [159:0] conn_pool[96];

  task automatic random_phase(input int items, input int pool_n, input int tick_pct);
    beat_t b;
    logic [159:0] t;
    logic busy_run;
    busy_run = 1'b0;
    for (int i = 0; i < pool_n; i++)
      conn_pool[i] = {$urandom, $urandom, $urandom, $urandom, $urandom};
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) busy_run = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) t = {$urandom, $urandom, $urandom, $urandom, $urandom};
      else t = conn_pool[$urandom_range(0, pool_n - 1)];
      b.kind = ($urandom_range(0, 99) < tick_pct) ? fbnhs_pkg::KIND_TICK
                                                  : fbnhs_pkg::KIND_PACKET;
      {b.de, b.se, b.qos, b.da, b.sa} = t;
      b.cand = rand_mask();
      send_beat(b, 1'b0, '0);
      pause(rand_gap(busy_run));
    end
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    route_t want;
    if (rst_ni && valid_o) begin
      if (routes_q.size() == 0) begin
        $display("%0t: result with nothing expected: port %0d status %0d hash %h",
                 $time, port_o, status_o, flow_hash_o);
        errors++;
      end else begin
        want = routes_q.pop_front();
        if (port_o !== want.port) begin
          $display("%0t: port expected %0d got %0d", $time, want.port, port_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          errors++;
        end
        if (flow_hash_o !== want.hash) begin
          $display("%0t: flow_hash expected %h got %h", $time, want.hash, flow_hash_o);
          errors++;
        end
        case (status_o)
          fbnhs_pkg::STATUS_EXIST: n_exist++;
          fbnhs_pkg::STATUS_NEW:   n_new++;
          default:                 n_none++;
        endcase
      end
    end
  end

  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_flow_balancing_next_hop_select_unit: done, errors");
        $finish;
      end
    end
  end

  row_t dir_rows[10];

  initial begin
    clear_model();
    // zero tuple hashes to zero; after reset the first lfsr step is 0x80200003
    dir_rows[0] = '{'{fbnhs_pkg::KIND_PACKET, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 64'h0},
                    1'b1, '{6'd0, fbnhs_pkg::STATUS_NONE, 16'h0}};
    dir_rows[1] = '{'{fbnhs_pkg::KIND_PACKET, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 64'h20},
                    1'b1, '{6'd5, fbnhs_pkg::STATUS_NEW, 16'h0}};
    dir_rows[2] = '{'{fbnhs_pkg::KIND_PACKET, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, '1},
                    1'b1, '{6'd5, fbnhs_pkg::STATUS_EXIST, 16'h0}};
    // known flow whose port left the candidate set
    dir_rows[3] = '{'{fbnhs_pkg::KIND_PACKET, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, ~64'h20},
                    1'b0, '0};
    dir_rows[4] = '{'{fbnhs_pkg::KIND_PACKET, '1, '1, '1, '1, '1, '1}, 1'b0, '0};
    dir_rows[5] = '{'{fbnhs_pkg::KIND_PACKET, '1, '1, '1, '1, '1, 64'h8000_0000_0000_0000},
                    1'b0, '0};
    dir_rows[6] = '{'{fbnhs_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0}, 1'b0, '0};
    dir_rows[7] = '{'{fbnhs_pkg::KIND_PACKET, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000,
                      32'h0000_FFFF, 32'h1234_5678, 64'hF0F0_0F0F_AAAA_5555}, 1'b0, '0};
    dir_rows[8] = '{'{fbnhs_pkg::KIND_PACKET, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_FFFF,
                      32'hFFFF_0000, 32'h8765_4321, 64'h1}, 1'b0, '0};
    dir_rows[9] = '{'{fbnhs_pkg::KIND_PACKET, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000,
                      32'h0000_FFFF, 32'h1234_5678, '1}, 1'b0, '0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].want);
      pause(i % 3);
    end
    wait_idle();
    random_phase(60, 16, 10);

    // least flows, short timeout: expiry releases load
    write_reg(fbnhs_pkg::CFG_MODE, {31'b0, fbnhs_pkg::MODE_LEAST});
    write_reg(fbnhs_pkg::CFG_TIMEOUT, 32'd3);
    random_phase(80, 16, 20);

    // random choice, zero timeout, zero seed
    write_reg(fbnhs_pkg::CFG_MODE, {31'b0, fbnhs_pkg::MODE_RANDOM});
    write_reg(fbnhs_pkg::CFG_TIMEOUT, 32'd0);
    write_reg(fbnhs_pkg::CFG_SEED, 32'd0);
    random_phase(70, 12, 25);

    // entries never expire: fill the table
    write_reg(fbnhs_pkg::CFG_MODE, {31'b0, fbnhs_pkg::MODE_LEAST});
    write_reg(fbnhs_pkg::CFG_TIMEOUT, '1);
    random_phase(100, 96, 2);

    write_reg(fbnhs_pkg::CFG_MODE, {31'b0, fbnhs_pkg::MODE_RANDOM});
    write_reg(fbnhs_pkg::CFG_SEED, '1);
    random_phase(60, 96, 5);

    // drain the full table, then churn
    write_reg(fbnhs_pkg::CFG_TIMEOUT, 32'd2);
    write_reg(fbnhs_pkg::CFG_SEED, $urandom | 32'h1);
    random_phase(70, 24, 20);

    write_reg(fbnhs_pkg::CFG_MODE, {31'b0, fbnhs_pkg::MODE_LEAST});
    write_reg(fbnhs_pkg::CFG_TIMEOUT, 32'd10);
    random_phase(70, 20, 15);

    wait_idle();
    $display("covered %0d packets and %0d ticks", n_pkt, n_tick);
    $display("results: %0d existing, %0d new, %0d no port", n_exist, n_new, n_none);
    if (errors == 0 && routes_q.size() == 0) begin
      $display("tb_flow_balancing_next_hop_select_unit: done, clean");
    end else begin
      $display("%0t: %0d mismatches, %0d results never came", $time, errors, routes_q.size());
      $display("tb_flow_balancing_next_hop_select_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: flow_balancing_next_hop_select_unit.f
hdl/fbnhs_pkg.sv
hdl/fbnhs_flow_cell.sv
hdl/fbnhs_port_cell.sv
hdl/flow_balancing_next_hop_select_unit.sv
tb/tb_flow_balancing_next_hop_select_unit.sv
